// ----- rtl/core/eodet_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the energy onset detector: widths, register indexes and reset values.
package eodet_pkg;

   // Default structural sizes handed to the top level.
   localparam int WINDOW_LENGTH_DEF = 512;
   localparam int SAMPLE_BITS_DEF   = 16;

   // Field widths fixed by the register map and the result format.
   localparam int THR_W    = 31;
   localparam int HOP_W    = 13;
   localparam int CNT_W    = 20;
   localparam int ENERGY_W = 31;
   localparam int CSR_W    = 31;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOP_LENGTH         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY_SAMPLES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_SAMPLES      = 2'd3;

   // Register values after reset.
   localparam logic [THR_W-1:0] THRESHOLD_RESET  = 31'd1073742;
   localparam logic [HOP_W-1:0] HOP_RESET        = 13'd256;
   localparam logic [CNT_W-1:0] REFRACTORY_RESET = 20'd22050;
   localparam logic [CNT_W-1:0] PULSE_RESET      = 20'd2205;

endpackage

// ----- rtl/core/energy_onset_detector_core.sv -----
`timescale 1ns / 1ps
// Top level of the energy onset detector: running energy, onset decision and pulse timing.
// The block takes one audio sample per clock, unless req_stall is raised, and returns one
// result transaction per sample while rsp_stall is low. A sample passes the window stages
// A and B, then the energy stage and the decision stage, before its result is offered.
// The sample rate is set by the single-port window memory, which writes the new sample
// and reads the sample it overwrites in the same cycle; the window needs no clearing
// after reset because entries are counted as zero until the write pointer has wrapped
// once. Every hop_length samples the mean energy (sum of squares over the window,
// shifted by log2 of the window length and saturated to 31 bits) is compared with
// energy_threshold; an onset restarts the refractory and pulse counters, which count
// down once per sample. Write the configuration registers only while the block is idle.
module energy_onset_detector_core import eodet_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration write port.
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_wr_data,
   // Sample channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_onset,
   output logic                          rsp_pin_level,
   output logic                          rsp_tone_gate,
   output logic                          rsp_energy_valid,
   output logic [ENERGY_W-1:0]           rsp_energy
);

   localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
   localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(WINDOW_LENGTH);
   localparam int SHIFT = $clog2(WINDOW_LENGTH + 1) - 1;
   localparam int EXT_W = SUM_W + ENERGY_W;

   // Configuration registers.
   logic [THR_W-1:0] threshold_ff;
   logic [HOP_W-1:0] hop_length_ff;
   logic [CNT_W-1:0] refractory_samples_ff;
   logic [CNT_W-1:0] pulse_samples_ff;

   // Window stage outputs.
   logic            win_ready, win_valid;
   logic [SQ_W-1:0] sq_new, sq_old;

   // Energy stage.
   logic             c_valid_ff, c_valid_in;
   logic [SUM_W-1:0] square_sum_ff, square_sum_in;
   logic [HOP_W-1:0] hop_count_ff, hop_count_in;
   logic             c_eval_ff, c_eval_in;
   logic [SUM_W-1:0] c_sum_ff;
   logic [HOP_W-1:0] hop_next;

   // Decision stage.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    refractory_ff, refractory_in;
   logic [CNT_W-1:0]    pulse_ff, pulse_in;
   logic                pin_ff, pin_in;
   logic                onset_ff, onset_in;
   logic                gate_ff, gate_in;
   logic                eval_ff;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [EXT_W-1:0]    mean_ext;
   logic [ENERGY_W-1:0] mean_sat;
   logic [CNT_W-1:0]    refractory_load, pulse_load;

   logic en_c, en_d, step_c, step_d;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff          <= THRESHOLD_RESET;
         hop_length_ff         <= HOP_RESET;
         refractory_samples_ff <= REFRACTORY_RESET;
         pulse_samples_ff      <= PULSE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENERGY_THRESHOLD: begin
               threshold_ff <= csr_wr_data[THR_W-1:0];
            end
            CSR_HOP_LENGTH: begin
               hop_length_ff <= csr_wr_data[HOP_W-1:0];
            end
            CSR_REFRACTORY_SAMPLES: begin
               refractory_samples_ff <= csr_wr_data[CNT_W-1:0];
            end
            CSR_PULSE_SAMPLES: begin
               pulse_samples_ff <= csr_wr_data[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow: a stage moves when it is empty or its successor moves.
   assign en_d   = !rsp_valid_ff || !rsp_stall;
   assign en_c   = !c_valid_ff || en_d;
   assign step_c = win_valid && en_c;
   assign step_d = c_valid_ff && en_d;

   assign req_stall = !win_ready;

   eodet_window #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (win_ready),
      .in_sample(req_sample),
      .out_valid(win_valid),
      .out_ready(en_c),
      .sq_new   (sq_new),
      .sq_old   (sq_old)
   );

   // Running sum of squares and the hop counter.
   assign hop_next = hop_count_ff + HOP_W'(1);

   always_comb begin
      square_sum_in = square_sum_ff;
      hop_count_in  = hop_count_ff;
      c_eval_in     = c_eval_ff;
      if (step_c) begin
         square_sum_in = square_sum_ff + SUM_W'(sq_new) - SUM_W'(sq_old);
         c_eval_in     = (hop_next >= hop_length_ff);
         hop_count_in  = c_eval_in ? '0 : hop_next;
      end
   end

   assign c_valid_in = en_c ? win_valid : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff    <= 1'b0;
         square_sum_ff <= '0;
         hop_count_ff  <= '0;
         c_eval_ff     <= 1'b0;
      end else begin
         c_valid_ff    <= c_valid_in;
         square_sum_ff <= square_sum_in;
         hop_count_ff  <= hop_count_in;
         c_eval_ff     <= c_eval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_c) begin
         c_sum_ff <= square_sum_in;
      end
   end

   // Mean energy, saturated to the result field.
   assign mean_ext = {{ENERGY_W{1'b0}}, c_sum_ff} >> SHIFT;
   assign mean_sat = (|mean_ext[EXT_W-1:ENERGY_W]) ? '1 : mean_ext[ENERGY_W-1:0];

   // Onset decision, refractory and pulse counters, marker pin.
   always_comb begin
      onset_in        = c_eval_ff && (mean_sat >= threshold_ff) && (refractory_ff == '0);
      refractory_load = onset_in ? refractory_samples_ff : refractory_ff;
      pulse_load      = onset_in ? pulse_samples_ff : pulse_ff;
      gate_in         = (pulse_load != '0);
      refractory_in   = (refractory_load != '0) ? refractory_load - CNT_W'(1) : '0;
      pulse_in        = gate_in ? pulse_load - CNT_W'(1) : '0;
      pin_in          = onset_in ? 1'b1 : pin_ff;
      if (gate_in && (pulse_in == '0)) begin
         pin_in = 1'b0;
      end
      energy_in = c_eval_ff ? mean_sat : '0;
   end

   assign rsp_valid_in = en_d ? c_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         refractory_ff <= '0;
         pulse_ff      <= '0;
         pin_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step_d) begin
            refractory_ff <= refractory_in;
            pulse_ff      <= pulse_in;
            pin_ff        <= pin_in;
         end
      end
   end

   // Result transaction payload.
   always_ff @(posedge clock) begin
      if (step_d) begin
         onset_ff  <= onset_in;
         gate_ff   <= gate_in;
         eval_ff   <= c_eval_ff;
         energy_ff <= energy_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_onset        = onset_ff;
   assign rsp_pin_level    = pin_ff;
   assign rsp_tone_gate    = gate_ff;
   assign rsp_energy_valid = eval_ff;
   assign rsp_energy       = energy_ff;

endmodule

// ----- rtl/core/eodet_window.sv -----
`timescale 1ns / 1ps
// Circular sample window with the new and evicted sample squares, two pipeline stages.
module eodet_window import eodet_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*SAMPLE_BITS-2:0]      sq_new,
   output logic [2*SAMPLE_BITS-2:0]      sq_old
);

   localparam int PTR_W = $clog2(WINDOW_LENGTH);
   localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);

   logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_LENGTH];

   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic                          wrapped_ff, wrapped_in;
   logic                          a_valid_ff, a_valid_in;
   logic                          a_evict_ff, a_evict_in;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic signed [SAMPLE_BITS-1:0] a_old_ff;
   logic                          b_valid_ff, b_valid_in;
   logic [SQ_W-1:0]               sq_new_ff, sq_new_in;
   logic [SQ_W-1:0]               sq_old_ff, sq_old_in;

   logic                            en_a, en_b, accept;
   logic signed [2*SAMPLE_BITS-1:0] prod_new, prod_old;

   // A stage moves when it is empty or the stage after it moves.
   assign en_b     = !b_valid_ff || out_ready;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;
   assign accept   = in_valid && en_a;

   // Window memory: the evicted sample is read while the new one is written.
   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[wr_ptr_ff] <= in_sample;
         a_old_ff              <= window_mem[wr_ptr_ff];
         a_sample_ff           <= in_sample;
      end
   end

   // Write pointer and the flag that marks every entry as written once.
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      wrapped_in = wrapped_ff;
      a_evict_in = a_evict_ff;
      if (accept) begin
         a_evict_in = wrapped_ff;
         if (wr_ptr_ff == PTR_LAST) begin
            wr_ptr_in  = '0;
            wrapped_in = 1'b1;
         end else begin
            wr_ptr_in = wr_ptr_ff + PTR_W'(1);
         end
      end
   end

   assign a_valid_in = en_a ? in_valid : a_valid_ff;
   assign b_valid_in = en_b ? a_valid_ff : b_valid_ff;

   // Squares of the new sample and of the evicted one; an unwritten entry counts as zero.
   assign prod_new  = a_sample_ff * a_sample_ff;
   assign prod_old  = a_old_ff * a_old_ff;
   assign sq_new_in = prod_new[SQ_W-1:0];
   assign sq_old_in = a_evict_ff ? prod_old[SQ_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         wrapped_ff <= 1'b0;
         a_evict_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         wrapped_ff <= wrapped_in;
         a_evict_ff <= a_evict_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         sq_new_ff <= sq_new_in;
         sq_old_ff <= sq_old_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign sq_new    = sq_new_ff;
   assign sq_old    = sq_old_ff;

endmodule
